FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion helpers
// concurrent checks on a clock with a synchronous reset, empty in synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: check failed");
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: check failed");
`else
`define ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

FILE: src/rov_pkg.sv
// ----------------------------------------------------------------------------
// rov_pkg
// shared constants, register map and helpers of the orbit vector field
// ----------------------------------------------------------------------------
package rov_pkg;

   localparam int CSR_W = 15;

   typedef enum logic [2:0] {
      CSR_HALF_WIDTH      = 3'd0,
      CSR_HALF_HEIGHT     = 3'd1,
      CSR_MARGIN          = 3'd2,
      CSR_FORWARD_SPEED   = 3'd3,
      CSR_CORRECTION_GAIN = 3'd4
   } csr_index_type;

   localparam logic [CSR_W-1:0] HALF_WIDTH_RST      = 15'd100;
   localparam logic [CSR_W-1:0] HALF_HEIGHT_RST     = 15'd100;
   localparam logic [CSR_W-1:0] MARGIN_RST          = 15'd20;
   localparam logic [CSR_W-1:0] FORWARD_SPEED_RST   = 15'd10;
   localparam logic [CSR_W-1:0] CORRECTION_GAIN_RST = 15'd1;

   // zones, row by row from the top left
   localparam logic [3:0] ZONE_TOP_LEFT     = 4'd1;
   localparam logic [3:0] ZONE_TOP          = 4'd2;
   localparam logic [3:0] ZONE_TOP_RIGHT    = 4'd3;
   localparam logic [3:0] ZONE_LEFT         = 4'd4;
   localparam logic [3:0] ZONE_CENTRE       = 4'd5;
   localparam logic [3:0] ZONE_RIGHT        = 4'd6;
   localparam logic [3:0] ZONE_BOTTOM_LEFT  = 4'd7;
   localparam logic [3:0] ZONE_BOTTOM       = 4'd8;
   localparam logic [3:0] ZONE_BOTTOM_RIGHT = 4'd9;

   localparam logic signed [79:0] INT32_MAX_W = 80'sd2147483647;
   localparam logic signed [79:0] INT32_MIN_W = -80'sd2147483648;

   // clamp a wide signed value to the signed 32-bit range
   function automatic logic [31:0] sat32(input logic signed [79:0] v);
      logic [31:0] r;
      if (v > INT32_MAX_W) begin
         r = 32'h7FFF_FFFF;
      end else if (v < INT32_MIN_W) begin
         r = 32'h8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

FILE: src/rov_sqrt.sv
// ----------------------------------------------------------------------------
// rov_sqrt
// pipelined floor square root of a 64-bit value, one root bit per stage
// ----------------------------------------------------------------------------
module rov_sqrt #(
   parameter int TAG_W = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  logic [63:0]      in_rad,
   input  logic [TAG_W-1:0] in_tag,
   output logic             out_valid,
   output logic [31:0]      out_root,
   output logic [TAG_W-1:0] out_tag
);

   localparam int STEPS = 32;

   logic             vld_ff  [STEPS];
   logic [33:0]      rem_ff  [STEPS];
   logic [31:0]      root_ff [STEPS];
   logic [63:0]      rad_ff  [STEPS];
   logic [TAG_W-1:0] tag_ff  [STEPS];

   for (genvar k = 0; k < STEPS; k++) begin : g_step
      logic             vld_prev;
      logic [33:0]      rem_prev;
      logic [31:0]      root_prev;
      logic [63:0]      rad_prev;
      logic [TAG_W-1:0] tag_prev;
      logic [35:0]      cur;
      logic [35:0]      trial;
      logic [33:0]      rem_in;
      logic [31:0]      root_in;

      if (k == 0) begin : g_first
         assign vld_prev  = in_valid;
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign rad_prev  = in_rad;
         assign tag_prev  = in_tag;
      end else begin : g_next
         assign vld_prev  = vld_ff[k-1];
         assign rem_prev  = rem_ff[k-1];
         assign root_prev = root_ff[k-1];
         assign rad_prev  = rad_ff[k-1];
         assign tag_prev  = tag_ff[k-1];
      end

      // bring down two radicand bits and try a one
      always_comb begin
         cur   = {rem_prev, rad_prev[63:62]};
         trial = {2'b00, root_prev, 2'b01};
         if (cur >= trial) begin
            rem_in  = 34'(cur - trial);
            root_in = {root_prev[30:0], 1'b1};
         end else begin
            rem_in  = cur[33:0];
            root_in = {root_prev[30:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= vld_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
            rad_ff[k]  <= {rad_prev[61:0], 2'b00};
            tag_ff[k]  <= tag_prev;
         end
      end
   end

   assign out_valid = vld_ff[STEPS-1];
   assign out_root  = root_ff[STEPS-1];
   assign out_tag   = tag_ff[STEPS-1];

endmodule

FILE: src/rov_div.sv
// ----------------------------------------------------------------------------
// rov_div
// pipelined restoring division of two dividends by one shared divisor
// ----------------------------------------------------------------------------
module rov_div #(
   parameter int QW    = 17,
   parameter int NW    = 48,
   parameter int TAG_W = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  logic [NW-1:0]    in_num_a,
   input  logic [NW-1:0]    in_num_b,
   input  logic [31:0]      in_den,
   input  logic [TAG_W-1:0] in_tag,
   output logic             out_valid,
   output logic [QW-1:0]    out_quo_a,
   output logic [QW-1:0]    out_quo_b,
   output logic [TAG_W-1:0] out_tag
);

   logic             vld_ff [QW];
   logic [NW-1:0]    ra_ff  [QW];
   logic [NW-1:0]    rb_ff  [QW];
   logic [QW-1:0]    qa_ff  [QW];
   logic [QW-1:0]    qb_ff  [QW];
   logic [31:0]      den_ff [QW];
   logic [TAG_W-1:0] tag_ff [QW];

   for (genvar k = 0; k < QW; k++) begin : g_step
      localparam int BIT = QW - 1 - k;
      logic             vld_prev;
      logic [NW-1:0]    ra_prev;
      logic [NW-1:0]    rb_prev;
      logic [QW-1:0]    qa_prev;
      logic [QW-1:0]    qb_prev;
      logic [31:0]      den_prev;
      logic [TAG_W-1:0] tag_prev;
      logic [NW-1:0]    den_sh;
      logic             take_a;
      logic             take_b;

      if (k == 0) begin : g_first
         assign vld_prev = in_valid;
         assign ra_prev  = in_num_a;
         assign rb_prev  = in_num_b;
         assign qa_prev  = '0;
         assign qb_prev  = '0;
         assign den_prev = in_den;
         assign tag_prev = in_tag;
      end else begin : g_next
         assign vld_prev = vld_ff[k-1];
         assign ra_prev  = ra_ff[k-1];
         assign rb_prev  = rb_ff[k-1];
         assign qa_prev  = qa_ff[k-1];
         assign qb_prev  = qb_ff[k-1];
         assign den_prev = den_ff[k-1];
         assign tag_prev = tag_ff[k-1];
      end

      assign den_sh = NW'(den_prev) << BIT;
      assign take_a = (ra_prev >= den_sh);
      assign take_b = (rb_prev >= den_sh);

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= vld_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            ra_ff[k]  <= take_a ? ra_prev - den_sh : ra_prev;
            rb_ff[k]  <= take_b ? rb_prev - den_sh : rb_prev;
            qa_ff[k]  <= {qa_prev[QW-2:0], take_a};
            qb_ff[k]  <= {qb_prev[QW-2:0], take_b};
            den_ff[k] <= den_prev;
            tag_ff[k] <= tag_prev;
         end
      end
   end

   assign out_valid = vld_ff[QW-1];
   assign out_quo_a = qa_ff[QW-1];
   assign out_quo_b = qb_ff[QW-1];
   assign out_tag   = tag_ff[QW-1];

endmodule

FILE: src/rov_outbuf.sv
// ----------------------------------------------------------------------------
// rov_outbuf
// output register with a skid stage, holds the pipeline only when both are full
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rov_outbuf #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  logic [WIDTH-1:0] in_data,
   output logic             en,
   output logic             out_valid,
   output logic [WIDTH-1:0] out_data,
   input  logic             out_stall
);

   logic             out_valid_ff;
   logic             skid_valid_ff;
   logic [WIDTH-1:0] out_data_ff;
   logic [WIDTH-1:0] skid_data_ff;
   logic             held;

   assign held = out_valid_ff && out_stall;
   assign en   = !skid_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (!out_stall) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (held) begin
         skid_valid_ff <= in_valid;
      end else begin
         out_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (!out_stall) begin
            out_data_ff <= skid_data_ff;
         end
      end else if (held) begin
         skid_data_ff <= in_data;
      end else begin
         out_data_ff <= in_data;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

   `ASSERT_IMPL(a_skid_behind_out, clock, reset, skid_valid_ff, out_valid_ff)
   `ASSERT_NEXT(a_skid_kept, clock, reset, skid_valid_ff && out_stall, skid_valid_ff)
   `ASSERT_NEXT(a_drain, clock, reset, out_valid_ff && !out_stall && !skid_valid_ff && !in_valid, !out_valid_ff)

endmodule

FILE: src/rect_orbit_vector_field.sv
// ----------------------------------------------------------------------------
// rect_orbit_vector_field
// guidance vector that makes a robot orbit a configured rectangle
// ----------------------------------------------------------------------------
//  channel  | direction | handshake             | payload
//  req      | in        | req_valid / req_stall | pos_x, pos_y, turn_ccw
//  rsp      | out       | rsp_valid / rsp_stall | zone, dir_x, dir_y, fault
//  csr      | in        | csr_valid / csr_ready | index, data (write only)
//
//  one beat per cycle in while req_stall is low, one per cycle out while rsp_stall
//  is low; the pipeline holds 4 front stages, 32 square root stages,
//  FRAC_BITS + 1 divider stages, 3 product stages and the output register
//  reset is synchronous: pipeline emptied, registers back to defaults
//  a stalled result moves into the skid stage; req_stall rises only once
//  the output register and the skid stage both hold a beat
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rect_orbit_vector_field #(
   parameter int FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   // request
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic               req_turn_ccw,
   // response
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [3:0]         rsp_zone,
   output logic signed [31:0] rsp_dir_x,
   output logic signed [31:0] rsp_dir_y,
   output logic               rsp_fault,
   // register writes
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [14:0]        csr_data
);

   localparam int F   = FRAC_BITS;
   // width of d = margin - corner distance
   localparam int DW  = ((F + 15 > 33) ? F + 15 : 33) + 1;
   // width of boundaries and side errors
   localparam int EW  = DW + 2;
   localparam int VW  = F + 17;
   localparam int UW  = F + 2;
   localparam int QW  = F + 1;
   localparam int NW  = 32 + F;
   localparam int PW  = DW + UW + 1;
   localparam int NXW = PW + 1;
   localparam int BW  = UW + 17;
   localparam int SW  = NXW + 1;

   // --------------------------------------------------------------------------
   // configuration registers
   // --------------------------------------------------------------------------
   logic [14:0] hw_ff, hh_ff, margin_ff, speed_ff, gain_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         hw_ff     <= rov_pkg::HALF_WIDTH_RST;
         hh_ff     <= rov_pkg::HALF_HEIGHT_RST;
         margin_ff <= rov_pkg::MARGIN_RST;
         speed_ff  <= rov_pkg::FORWARD_SPEED_RST;
         gain_ff   <= rov_pkg::CORRECTION_GAIN_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            rov_pkg::CSR_HALF_WIDTH:      hw_ff     <= csr_data;
            rov_pkg::CSR_HALF_HEIGHT:     hh_ff     <= csr_data;
            rov_pkg::CSR_MARGIN:          margin_ff <= csr_data;
            rov_pkg::CSR_FORWARD_SPEED:   speed_ff  <= csr_data;
            rov_pkg::CSR_CORRECTION_GAIN: gain_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   // --------------------------------------------------------------------------
   // pipeline enable from the output side
   // --------------------------------------------------------------------------
   logic en;

   assign req_stall = !en;

   // --------------------------------------------------------------------------
   // stage 1: input register
   // --------------------------------------------------------------------------
   logic               s1_valid_ff;
   logic signed [31:0] s1_x_ff, s1_y_ff;
   logic               s1_ccw_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_x_ff   <= req_pos_x;
         s1_y_ff   <= req_pos_y;
         s1_ccw_ff <= req_turn_ccw;
      end
   end

   // --------------------------------------------------------------------------
   // stage 2: column / row compares, diagonal products, corner offsets,
   // side errors
   // --------------------------------------------------------------------------
   logic signed [EW-1:0] x_e, y_e, w_v, h_v, m_v, cx, cy, ex_w, ey_w;
   logic signed [EW-1:0] e_top, e_left, e_right, e_bot;
   logic signed [47:0]   lhs, rhs;
   logic                 col_l, col_r, row_t, row_b;

   assign x_e = EW'(s1_x_ff);
   assign y_e = EW'(s1_y_ff);
   assign w_v = EW'(hw_ff) << F;
   assign h_v = EW'(hh_ff) << F;
   assign m_v = EW'(margin_ff) << F;

   assign col_r = (x_e >= w_v);
   assign col_l = (x_e < -w_v);
   assign row_t = (y_e >= h_v);
   assign row_b = (y_e < -h_v);

   assign lhs = s1_y_ff * $signed({1'b0, hw_ff});
   assign rhs = s1_x_ff * $signed({1'b0, hh_ff});

   // corner offset stays inside 32 bits whenever the zone is a corner
   assign cx   = col_l ? -w_v : w_v;
   assign cy   = row_t ? h_v : -h_v;
   assign ex_w = x_e - cx;
   assign ey_w = y_e - cy;

   assign e_top   = h_v + m_v - y_e;
   assign e_left  = -w_v - m_v - x_e;
   assign e_right = w_v + m_v - x_e;
   assign e_bot   = -h_v - m_v - y_e;

   logic                 s2_valid_ff;
   logic                 s2_ccw_ff;
   logic                 s2_col_l_ff, s2_col_r_ff, s2_row_t_ff, s2_row_b_ff;
   logic signed [47:0]   s2_lhs_ff, s2_rhs_ff;
   logic [31:0]          s2_ex_ff, s2_ey_ff;
   logic signed [EW-1:0] s2_e_top_ff, s2_e_left_ff, s2_e_right_ff, s2_e_bot_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (en) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_ccw_ff     <= s1_ccw_ff;
         s2_col_l_ff   <= col_l;
         s2_col_r_ff   <= col_r;
         s2_row_t_ff   <= row_t;
         s2_row_b_ff   <= row_b;
         s2_lhs_ff     <= lhs;
         s2_rhs_ff     <= rhs;
         s2_ex_ff      <= ex_w[31:0];
         s2_ey_ff      <= ey_w[31:0];
         s2_e_top_ff   <= e_top;
         s2_e_left_ff  <= e_left;
         s2_e_right_ff <= e_right;
         s2_e_bot_ff   <= e_bot;
      end
   end

   // --------------------------------------------------------------------------
   // stage 3: zone, side gain product, squares of the corner offset
   // --------------------------------------------------------------------------
   logic signed [48:0]    cen_sum;
   logic                  diag_a, diag_c;
   logic [3:0]            zone3;
   logic                  corner3;
   logic signed [EW-1:0]  err_sel;
   logic                  on_x, v_pos;
   logic signed [EW+15:0] prod;
   logic signed [VW-1:0]  v_full;
   logic [31:0]           magx, magy;
   logic [63:0]           sqx, sqy;

   assign cen_sum = 49'(s2_lhs_ff) + 49'(s2_rhs_ff);
   assign diag_a  = (cen_sum >= 0);
   assign diag_c  = (s2_lhs_ff >= s2_rhs_ff);

   always_comb begin
      priority if (s2_row_t_ff && s2_col_l_ff) begin
         zone3 = rov_pkg::ZONE_TOP_LEFT;
      end else if (s2_row_t_ff && s2_col_r_ff) begin
         zone3 = rov_pkg::ZONE_TOP_RIGHT;
      end else if (s2_row_t_ff) begin
         zone3 = rov_pkg::ZONE_TOP;
      end else if (s2_row_b_ff && s2_col_l_ff) begin
         zone3 = rov_pkg::ZONE_BOTTOM_LEFT;
      end else if (s2_row_b_ff && s2_col_r_ff) begin
         zone3 = rov_pkg::ZONE_BOTTOM_RIGHT;
      end else if (s2_row_b_ff) begin
         zone3 = rov_pkg::ZONE_BOTTOM;
      end else if (s2_col_l_ff) begin
         zone3 = rov_pkg::ZONE_LEFT;
      end else if (s2_col_r_ff) begin
         zone3 = rov_pkg::ZONE_RIGHT;
      end else if (diag_a && diag_c) begin
         // inside the rectangle: split by the diagonals
         zone3 = rov_pkg::ZONE_TOP;
      end else if (diag_a) begin
         zone3 = rov_pkg::ZONE_RIGHT;
      end else if (diag_c) begin
         zone3 = rov_pkg::ZONE_LEFT;
      end else begin
         zone3 = rov_pkg::ZONE_BOTTOM;
      end
   end

   assign corner3 = (s2_row_t_ff || s2_row_b_ff) && (s2_col_l_ff || s2_col_r_ff);

   // gain product goes on one axis, forward speed on the other
   always_comb begin
      unique case (zone3)
         rov_pkg::ZONE_TOP: begin
            err_sel = s2_e_top_ff;
            on_x    = 1'b0;
            v_pos   = s2_ccw_ff;
         end
         rov_pkg::ZONE_LEFT: begin
            err_sel = s2_e_left_ff;
            on_x    = 1'b1;
            v_pos   = s2_ccw_ff;
         end
         rov_pkg::ZONE_RIGHT: begin
            err_sel = s2_e_right_ff;
            on_x    = 1'b1;
            v_pos   = !s2_ccw_ff;
         end
         rov_pkg::ZONE_BOTTOM: begin
            err_sel = s2_e_bot_ff;
            on_x    = 1'b0;
            v_pos   = !s2_ccw_ff;
         end
         default: begin
            err_sel = '0;
            on_x    = 1'b0;
            v_pos   = s2_ccw_ff;
         end
      endcase
   end

   assign prod   = err_sel * $signed({1'b0, gain_ff});
   assign v_full = VW'(speed_ff) << F;

   assign magx = s2_ex_ff[31] ? (~s2_ex_ff + 32'd1) : s2_ex_ff;
   assign magy = s2_ey_ff[31] ? (~s2_ey_ff + 32'd1) : s2_ey_ff;
   assign sqx  = magx * magx;
   assign sqy  = magy * magy;

   logic                  s3_valid_ff;
   logic [3:0]            s3_zone_ff;
   logic                  s3_corner_ff, s3_ccw_ff, s3_sx_neg_ff, s3_sy_neg_ff, s3_on_x_ff;
   logic [31:0]           s3_magx_ff, s3_magy_ff;
   logic [63:0]           s3_sqx_ff, s3_sqy_ff;
   logic signed [EW+15:0] s3_prod_ff;
   logic signed [VW-1:0]  s3_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (en) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s3_zone_ff   <= zone3;
         s3_corner_ff <= corner3;
         s3_ccw_ff    <= s2_ccw_ff;
         s3_sx_neg_ff <= s2_ex_ff[31];
         s3_sy_neg_ff <= s2_ey_ff[31];
         s3_on_x_ff   <= on_x;
         s3_magx_ff   <= magx;
         s3_magy_ff   <= magy;
         s3_sqx_ff    <= sqx;
         s3_sqy_ff    <= sqy;
         s3_prod_ff   <= prod;
         s3_v_ff      <= v_pos ? v_full : -v_full;
      end
   end

   // --------------------------------------------------------------------------
   // stage 4: radicand and saturated side results
   // --------------------------------------------------------------------------
   typedef struct packed {
      logic [3:0]  zone;
      logic        corner;
      logic        ccw;
      logic        sx_neg;
      logic        sy_neg;
      logic [31:0] magx;
      logic [31:0] magy;
      logic [31:0] side_x;
      logic [31:0] side_y;
   } sq_tag_type;

   logic [31:0] sat_prod, sat_v;
   sq_tag_type  s4_tag_in;

   assign sat_prod = rov_pkg::sat32(80'(s3_prod_ff));
   assign sat_v    = rov_pkg::sat32(80'(s3_v_ff));

   always_comb begin
      s4_tag_in.zone   = s3_zone_ff;
      s4_tag_in.corner = s3_corner_ff;
      s4_tag_in.ccw    = s3_ccw_ff;
      s4_tag_in.sx_neg = s3_sx_neg_ff;
      s4_tag_in.sy_neg = s3_sy_neg_ff;
      s4_tag_in.magx   = s3_magx_ff;
      s4_tag_in.magy   = s3_magy_ff;
      s4_tag_in.side_x = s3_on_x_ff ? sat_prod : sat_v;
      s4_tag_in.side_y = s3_on_x_ff ? sat_v : sat_prod;
   end

   logic        s4_valid_ff;
   logic [63:0] s4_rad_ff;
   sq_tag_type  s4_tag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (en) begin
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s4_rad_ff <= s3_sqx_ff + s3_sqy_ff;
         s4_tag_ff <= s4_tag_in;
      end
   end

   // --------------------------------------------------------------------------
   // corner distance: floor square root
   // --------------------------------------------------------------------------
   logic        sq_valid;
   logic [31:0] sq_root;
   sq_tag_type  sq_tag;

   rov_sqrt #(
      .TAG_W ($bits(sq_tag_type))
   ) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s4_valid_ff),
      .in_rad    (s4_rad_ff),
      .in_tag    (s4_tag_ff),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_tag   (sq_tag)
   );

   // --------------------------------------------------------------------------
   // unit vector: offset scaled by 2^F over the distance
   // --------------------------------------------------------------------------
   typedef struct packed {
      logic [3:0]           zone;
      logic                 corner;
      logic                 fault;
      logic                 ccw;
      logic                 sx_neg;
      logic                 sy_neg;
      logic signed [DW-1:0] d;
      logic [31:0]          side_x;
      logic [31:0]          side_y;
   } dv_tag_type;

   logic signed [DW-1:0] m_d;
   dv_tag_type           dv_tag_in;

   assign m_d = DW'(margin_ff) << F;

   always_comb begin
      dv_tag_in.zone   = sq_tag.zone;
      dv_tag_in.corner = sq_tag.corner;
      dv_tag_in.fault  = sq_tag.corner && (sq_root == 32'd0);
      dv_tag_in.ccw    = sq_tag.ccw;
      dv_tag_in.sx_neg = sq_tag.sx_neg;
      dv_tag_in.sy_neg = sq_tag.sy_neg;
      dv_tag_in.d      = m_d - $signed({{(DW-32){1'b0}}, sq_root});
      dv_tag_in.side_x = sq_tag.side_x;
      dv_tag_in.side_y = sq_tag.side_y;
   end

   logic          dv_valid;
   logic [QW-1:0] dv_qa, dv_qb;
   dv_tag_type    dv_tag;

   rov_div #(
      .QW    (QW),
      .NW    (NW),
      .TAG_W ($bits(dv_tag_type))
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (sq_valid),
      .in_num_a  ({sq_tag.magx, {F{1'b0}}}),
      .in_num_b  ({sq_tag.magy, {F{1'b0}}}),
      .in_den    (sq_root),
      .in_tag    (dv_tag_in),
      .out_valid (dv_valid),
      .out_quo_a (dv_qa),
      .out_quo_b (dv_qb),
      .out_tag   (dv_tag)
   );

   // --------------------------------------------------------------------------
   // product stage 1: radial and tangential products, d split in two halves
   // --------------------------------------------------------------------------
   typedef struct packed {
      logic [3:0]  zone;
      logic        corner;
      logic        fault;
      logic        ccw;
      logic [31:0] side_x;
      logic [31:0] side_y;
   } fin_tag_type;

   logic signed [UW-1:0]      ux, uy;
   logic signed [DW-17:0]     d_hi;
   logic signed [16:0]        d_lo;
   logic signed [DW-16+UW-1:0] phx, phy;
   logic signed [16+UW:0]     plx, ply;
   logic signed [UW+15:0]     vx, vy;
   fin_tag_type               m1_tag_in;

   assign ux   = dv_tag.sx_neg ? -$signed({1'b0, dv_qa}) : $signed({1'b0, dv_qa});
   assign uy   = dv_tag.sy_neg ? -$signed({1'b0, dv_qb}) : $signed({1'b0, dv_qb});
   assign d_hi = $signed(dv_tag.d[DW-1:16]);
   assign d_lo = $signed({1'b0, dv_tag.d[15:0]});
   assign phx  = d_hi * ux;
   assign phy  = d_hi * uy;
   assign plx  = d_lo * ux;
   assign ply  = d_lo * uy;
   assign vx   = $signed({1'b0, speed_ff}) * ux;
   assign vy   = $signed({1'b0, speed_ff}) * uy;

   always_comb begin
      m1_tag_in.zone   = dv_tag.zone;
      m1_tag_in.corner = dv_tag.corner;
      m1_tag_in.fault  = dv_tag.fault;
      m1_tag_in.ccw    = dv_tag.ccw;
      m1_tag_in.side_x = dv_tag.side_x;
      m1_tag_in.side_y = dv_tag.side_y;
   end

   logic                       m1_valid_ff;
   logic signed [DW-16+UW-1:0] m1_phx_ff, m1_phy_ff;
   logic signed [16+UW:0]      m1_plx_ff, m1_ply_ff;
   logic signed [UW+15:0]      m1_vx_ff, m1_vy_ff;
   fin_tag_type                m1_tag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_valid_ff <= 1'b0;
      end else if (en) begin
         m1_valid_ff <= dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m1_phx_ff <= phx;
         m1_phy_ff <= phy;
         m1_plx_ff <= plx;
         m1_ply_ff <= ply;
         m1_vx_ff  <= vx;
         m1_vy_ff  <= vy;
         m1_tag_ff <= m1_tag_in;
      end
   end

   // --------------------------------------------------------------------------
   // product stage 2: -d*u rebuilt from its halves and scaled down
   // --------------------------------------------------------------------------
   logic signed [NXW-1:0] nx, ny;

   assign nx = NXW'(0) - (NXW'(m1_phx_ff) <<< 16) - NXW'(m1_plx_ff);
   assign ny = NXW'(0) - (NXW'(m1_phy_ff) <<< 16) - NXW'(m1_ply_ff);

   logic                  m2_valid_ff;
   logic signed [NXW-1:0] m2_ax_ff, m2_ay_ff;
   logic signed [BW-1:0]  m2_bx_ff, m2_by_ff;
   fin_tag_type           m2_tag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         m2_valid_ff <= 1'b0;
      end else if (en) begin
         m2_valid_ff <= m1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m2_ax_ff  <= nx >>> F;
         m2_ay_ff  <= ny >>> F;
         // tangential push follows the travel sense
         m2_bx_ff  <= m1_tag_ff.ccw ? BW'(m1_vy_ff) : -BW'(m1_vy_ff);
         m2_by_ff  <= m1_tag_ff.ccw ? -BW'(m1_vx_ff) : BW'(m1_vx_ff);
         m2_tag_ff <= m1_tag_ff;
      end
   end

   // --------------------------------------------------------------------------
   // product stage 3: sum, saturate, pick side / corner / fault result
   // --------------------------------------------------------------------------
   typedef struct packed {
      logic [3:0]  zone;
      logic [31:0] dir_x;
      logic [31:0] dir_y;
      logic        fault;
   } rsp_type;

   logic signed [SW-1:0] sum_x, sum_y;
   rsp_type              m3_in;

   assign sum_x = SW'(m2_ax_ff) + SW'(m2_bx_ff);
   assign sum_y = SW'(m2_ay_ff) + SW'(m2_by_ff);

   always_comb begin
      m3_in.zone  = m2_tag_ff.zone;
      m3_in.fault = m2_tag_ff.fault;
      if (m2_tag_ff.fault) begin
         m3_in.dir_x = '0;
         m3_in.dir_y = '0;
      end else if (m2_tag_ff.corner) begin
         m3_in.dir_x = rov_pkg::sat32(80'(sum_x));
         m3_in.dir_y = rov_pkg::sat32(80'(sum_y));
      end else begin
         m3_in.dir_x = m2_tag_ff.side_x;
         m3_in.dir_y = m2_tag_ff.side_y;
      end
   end

   logic    m3_valid_ff;
   rsp_type m3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         m3_valid_ff <= 1'b0;
      end else if (en) begin
         m3_valid_ff <= m2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m3_ff <= m3_in;
      end
   end

   // --------------------------------------------------------------------------
   // output register and skid stage
   // --------------------------------------------------------------------------
   rsp_type rsp_data;

   rov_outbuf #(
      .WIDTH ($bits(rsp_type))
   ) u_outbuf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (m3_valid_ff),
      .in_data   (m3_ff),
      .en        (en),
      .out_valid (rsp_valid),
      .out_data  (rsp_data),
      .out_stall (rsp_stall)
   );

   assign rsp_zone  = rsp_data.zone;
   assign rsp_dir_x = rsp_data.dir_x;
   assign rsp_dir_y = rsp_data.dir_y;
   assign rsp_fault = rsp_data.fault;

   `ASSERT_IMPL(a_fault_zero_vector, clock, reset, rsp_valid && rsp_fault, rsp_dir_x == 32'sd0 && rsp_dir_y == 32'sd0)
   `ASSERT_IMPL(a_fault_on_corner, clock, reset, rsp_valid && rsp_fault, rsp_zone == rov_pkg::ZONE_TOP_LEFT || rsp_zone == rov_pkg::ZONE_TOP_RIGHT || rsp_zone == rov_pkg::ZONE_BOTTOM_LEFT || rsp_zone == rov_pkg::ZONE_BOTTOM_RIGHT)
   `ASSERT_IMPL(a_no_centre_zone, clock, reset, rsp_valid, rsp_zone != rov_pkg::ZONE_CENTRE && rsp_zone != 4'd0 && rsp_zone <= rov_pkg::ZONE_BOTTOM_RIGHT)

endmodule

FILE: test/tb_rect_orbit_vector_field.sv
// ----------------------------------------------------------------------------
// tb_rect_orbit_vector_field
// self-checking bench: positions go in through a random-idling driver, the
// guidance field is predicted in wide signed arithmetic, results are checked
// in order against the queue of predicted vectors
// ----------------------------------------------------------------------------
module tb_rect_orbit_vector_field;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAC = 16;
   localparam int DRAIN = FRAC + 41 + 20;
   localparam int WATCHDOG_LIMIT = 20000;

   typedef struct packed {
      logic [3:0]  zone;
      logic [31:0] dir_x;
      logic [31:0] dir_y;
      logic        fault;
   } guidance_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [31:0] req_pos_x = '0;
   logic signed [31:0] req_pos_y = '0;
   logic req_turn_ccw = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [3:0] rsp_zone;
   logic signed [31:0] rsp_dir_x;
   logic signed [31:0] rsp_dir_y;
   logic rsp_fault;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [2:0] csr_index = '0;
   logic [14:0] csr_data = '0;

   // predictor copy of the register file
   longint unsigned rect_w, rect_h, orbit_margin, travel_speed, side_gain;

   guidance_type vector_queue[$];
   int  fail_count = 0;
   int  idle_cycles = 0;
   bit  calm = 1'b0;         // no idling on either side while set

   rect_orbit_vector_field #(.FRAC_BITS(FRAC)) i_dut (.*);

   // clock, 4 ns period
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // exact floor square root on 128-bit operands
   function automatic logic [127:0] floor_sqrt(input logic [127:0] v);
      logic [127:0] r, b;
      r = 0;
      b = 128'd1 << 126;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic logic [31:0] clamp32(input logic signed [127:0] v);
      logic [31:0] r;
      if (v > 128'sd2147483647) r = 32'h7FFF_FFFF;
      else if (v < -128'sd2147483648) r = 32'h8000_0000;
      else r = v[31:0];
      return r;
   endfunction

   // arithmetic shift right by the fraction bits, rounding toward minus infinity
   function automatic logic signed [127:0] floor_frac(input logic signed [127:0] v);
      return v >>> FRAC;
   endfunction

   function automatic guidance_type predict_guidance(input logic signed [31:0] px,
                                                      input logic signed [31:0] py,
                                                      input logic ccw);
      logic signed [127:0] x, y, s, one, w, h, m, v, g, cx, cy, ex, ey, n, d, ux, uy;
      logic signed [127:0] lhs, rhs, rx, ry;
      int col, row;
      guidance_type r;
      x = px; y = py;
      s = ccw ? 1 : -1;
      one = 128'sd1 << FRAC;
      w = $signed({64'd0, rect_w}) * one;
      h = $signed({64'd0, rect_h}) * one;
      m = $signed({64'd0, orbit_margin}) * one;
      v = $signed({64'd0, travel_speed}) * one;
      g = $signed({64'd0, side_gain});
      col = (x >= w) ? 3 : (x < -w) ? 1 : 2;
      row = (y >= h) ? 1 : (y < -h) ? 3 : 2;
      r.zone = 4'(col + 3 * (row - 1));
      r.fault = 1'b0;
      rx = 0; ry = 0;
      if (r.zone == rov_pkg::ZONE_CENTRE) begin
         // diagonals split the inner rectangle
         lhs = y * $signed({64'd0, rect_w});
         rhs = x * $signed({64'd0, rect_h});
         if (lhs >= -rhs) r.zone = (lhs >= rhs) ? rov_pkg::ZONE_TOP : rov_pkg::ZONE_RIGHT;
         else r.zone = (lhs >= rhs) ? rov_pkg::ZONE_LEFT : rov_pkg::ZONE_BOTTOM;
      end
      case (r.zone)
         rov_pkg::ZONE_TOP: begin
            rx = s * v; ry = (h + m - y) * g;
         end
         rov_pkg::ZONE_LEFT: begin
            rx = (-w - m - x) * g; ry = s * v;
         end
         rov_pkg::ZONE_RIGHT: begin
            rx = (w + m - x) * g; ry = -s * v;
         end
         rov_pkg::ZONE_BOTTOM: begin
            rx = -s * v; ry = (-h - m - y) * g;
         end
         default: begin
            cx = (col == 1) ? -w : w;
            cy = (row == 1) ? h : -h;
            ex = x - cx;
            ey = y - cy;
            n = $signed(floor_sqrt(ex * ex + ey * ey));
            if (n == 0) begin
               r.fault = 1'b1;
            end else begin
               d = m - n;
               ux = (ex * one) / n;
               uy = (ey * one) / n;
               rx = floor_frac(-d * ux) + s * floor_frac(v * uy);
               ry = floor_frac(-d * uy) - s * floor_frac(v * ux);
            end
         end
      endcase
      r.dir_x = clamp32(rx);
      r.dir_y = clamp32(ry);
      return r;
   endfunction

   // one position beat, with random idle cycles in front
   task automatic send_position(input logic [31:0] px, input logic [31:0] py,
                                input logic ccw);
      while (!calm && $urandom_range(99) < 9) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pos_x <= px;
      req_pos_y <= py;
      req_turn_ccw <= ccw;
      vector_queue.push_back(predict_guidance(px, py, ccw));
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic release_request();
      req_valid <= 1'b0;
   endtask

   // wait for the pipeline to empty before touching registers
   task automatic drain_pipeline();
      release_request();
      while (vector_queue.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
   endtask

   // write beats follow back to back, the caller drops csr_valid afterwards
   task automatic write_register(input rov_pkg::csr_index_type idx,
                                 input logic [14:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         rov_pkg::CSR_HALF_WIDTH:    rect_w = val;
         rov_pkg::CSR_HALF_HEIGHT:   rect_h = val;
         rov_pkg::CSR_MARGIN:        orbit_margin = val;
         rov_pkg::CSR_FORWARD_SPEED: travel_speed = val;
         default:                    side_gain = val;
      endcase
   endtask

   task automatic load_geometry(input logic [14:0] w, input logic [14:0] h,
                                input logic [14:0] m, input logic [14:0] v,
                                input logic [14:0] g);
      drain_pipeline();
      write_register(rov_pkg::CSR_HALF_WIDTH, w);
      write_register(rov_pkg::CSR_HALF_HEIGHT, h);
      write_register(rov_pkg::CSR_MARGIN, m);
      write_register(rov_pkg::CSR_FORWARD_SPEED, v);
      write_register(rov_pkg::CSR_CORRECTION_GAIN, g);
      csr_valid <= 1'b0;
   endtask

   // a position near the rectangle, in whole or fractional units
   function automatic logic [31:0] near_edge(input longint unsigned half);
      longint span;
      span = (longint'(half) + longint'(orbit_margin) + 8) << FRAC;
      if (span > 64'sd2147483647) span = 64'sd2147483647;
      return 32'($urandom_range(0, 32'(span)) * (($urandom_range(1)) ? 1 : -1)
                 + $signed($urandom_range(0, 65535)) - 32768);
   endfunction

   // reset defaults, corners, edges and both directions
   task automatic test_directed();
      logic [31:0] wq, hq;
      wq = 32'(rect_w << FRAC);
      hq = 32'(rect_h << FRAC);
      send_position(wq, hq, 1'b1);                   // exactly on a corner
      send_position(-wq, -hq, 1'b0);                 // bottom-left corner point, inside: left zone
      send_position(wq, -hq, 1'b1);                  // right edge, bottom boundary
      send_position(-wq - 1, hq, 1'b0);              // just outside left
      send_position(-wq - 1, -hq - 1, 1'b1);
      send_position(0, 0, 1'b1);                     // centre, diagonal tie
      send_position(0, 0, 1'b0);
      send_position(32'h0001_0000, 0, 1'b1);
      send_position(0, 32'hFFFF_0000, 1'b0);
      send_position(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
      send_position(32'h8000_0000, 32'h8000_0000, 1'b0);
      send_position(32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
      send_position(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
      send_position(32'h7FFF_FFFF, 0, 1'b1);
      send_position(0, 32'h8000_0000, 1'b0);
      send_position(32'hFFFF_FFFF, 32'h0000_0001, 1'b1);
      send_position(wq + 32'h0005_0000, hq + 32'h0003_0000, 1'b0);
      send_position(-wq, 32'h0001_8000, 1'b1);       // left boundary is inside
      drain_pipeline();
   endtask

   // extreme register settings, including zero gain, speed and margin
   task automatic test_register_extremes();
      load_geometry(15'd1, 15'd1, 15'd0, 15'd0, 15'd0);
      send_position(32'h0001_0000, 32'h0001_0000, 1'b1);
      send_position(32'h0002_0000, 32'h0000_8000, 1'b0);
      send_position(32'h0000_4000, 32'hFFFF_C000, 1'b1);
      load_geometry(15'h7FFF, 15'h7FFF, 15'h7FFF, 15'h7FFF, 15'h7FFF);
      send_position(32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
      send_position(0, 32'h7FFF_0000, 1'b0);
      send_position(32'h7FFF_0000, 0, 1'b1);
      send_position(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
      send_position(32'h8001_0000, 32'h8000_0000, 1'b1);
      load_geometry(15'd1, 15'h7FFF, 15'd3, 15'h4000, 15'd2);
      send_position(32'h0000_FFFF, 32'h1234_5678, 1'b1);
      send_position(32'hFFFF_0000, 32'h8000_0000, 1'b0);
   endtask

   // random positions, mostly around the orbit, some anywhere
   task automatic test_random_positions(input int count);
      logic [31:0] px, py;
      for (int i = 0; i < count; i++) begin
         if (i % 50 == 0 && i != 0)
            load_geometry(15'($urandom_range(1, 500)), 15'($urandom_range(1, 500)),
                          15'($urandom_range(0, 200)), 15'($urandom_range(0, 32767)),
                          15'($urandom_range(0, 32767)));
         calm = (i % 300) >= 200;
         if ($urandom_range(9) < 7) begin
            px = near_edge(rect_w);
            py = near_edge(rect_h);
         end else begin
            px = $urandom();
            py = $urandom();
         end
         send_position(px, py, 1'($urandom_range(1)));
      end
      calm = 1'b0;
      drain_pipeline();
   endtask

   // result side: random stall and in-order comparison
   always @(posedge clock) begin
      guidance_type exp_v;
      rsp_stall <= reset ? 1'b0 : (!calm && $urandom_range(99) < 9);
      if (!reset && rsp_valid && !rsp_stall) begin
         if (vector_queue.size() == 0) begin
            $error("result beat with nothing expected");
            fail_count++;
         end else begin
            exp_v = vector_queue.pop_front();
            if (rsp_zone !== exp_v.zone) begin
               $error("zone expected %0d got %0d", exp_v.zone, rsp_zone);
               fail_count++;
            end
            if (rsp_dir_x !== exp_v.dir_x) begin
               $error("dir_x expected %0d got %0d", $signed(exp_v.dir_x), rsp_dir_x);
               fail_count++;
            end
            if (rsp_dir_y !== exp_v.dir_y) begin
               $error("dir_y expected %0d got %0d", $signed(exp_v.dir_y), rsp_dir_y);
               fail_count++;
            end
            if (rsp_fault !== exp_v.fault) begin
               $error("fault expected %0d got %0d", exp_v.fault, rsp_fault);
               fail_count++;
            end
         end
      end
   end

   // watchdog on cycles with no beat accepted anywhere
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      rect_w = rov_pkg::HALF_WIDTH_RST;
      rect_h = rov_pkg::HALF_HEIGHT_RST;
      orbit_margin = rov_pkg::MARGIN_RST;
      travel_speed = rov_pkg::FORWARD_SPEED_RST;
      side_gain = rov_pkg::CORRECTION_GAIN_RST;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_register_extremes();
      test_random_positions(1250);
      if (vector_queue.size() != 0) fail_count++;
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
